@@ rtl/ffpa_pkg.sv @@
package ffpa_pkg;

	// Arena geometry
	localparam int ARENA_BYTES  = 1024;
	localparam int HEADER_BYTES = 24;
	localparam int SPLIT_SLACK  = 4;

	localparam int ADDR_W = $clog2(ARENA_BYTES);
	localparam int SIZE_W = ADDR_W;
	localparam int SUM_W  = ADDR_W + 2;
	localparam int REQ_W  = 12;

	// Block header as kept in the header memory
	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	localparam hdr_t HDR_RESET = '{free: 1'b1, size: SIZE_W'(ARENA_BYTES - HEADER_BYTES)};

	// Request and result payloads
	typedef struct packed {
		logic             operation;
		logic [REQ_W-1:0] request_size;
		logic [9:0]       release_offset;
		logic             release_is_null;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] granted_offset;
	} rsp_t;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_GRANTED  = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_RELEASED = 2'd2;
	localparam logic [1:0] ST_NULL     = 2'd3;

	// Header write selection
	localparam logic [2:0] WR_NONE      = 3'd0;
	localparam logic [2:0] WR_SPLIT_NEW = 3'd1;
	localparam logic [2:0] WR_TAKE_REQ  = 3'd2;
	localparam logic [2:0] WR_TAKE_ALL  = 3'd3;
	localparam logic [2:0] WR_MARK_FREE = 3'd4;
	localparam logic [2:0] WR_MERGE     = 3'd5;

	// Controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       cur_zero;
		logic       cur_walk;
		logic       hold_load;
		logic       skip;
		logic       merge;
		logic       rd_nx;
		logic [2:0] wr_op;
		logic       finish;
		logic [1:0] fin_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op_rel;
		logic is_null;
		logic roff_low;
		logic fit;
		logic split;
		logic walk_end;
		logic at_target;
		logic past_target;
		logic both_free;
		logic merged_end;
		logic skip_end;
	} sts_t;

endpackage

@@ rtl/ffpa_datapath.sv @@
module ffpa_datapath import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output sts_t sts,
	output logic done,
	output rsp_t result
);

	localparam logic [SUM_W-1:0] HDR_S   = SUM_W'(HEADER_BYTES);
	localparam logic [SUM_W-1:0] ARENA_S = SUM_W'(ARENA_BYTES);

	req_t              in_q;
	logic [ADDR_W-1:0] cur_q;
	logic [ADDR_W-1:0] nx_q;
	logic              hold_free_q;
	logic [SIZE_W-1:0] hold_size_q;
	hdr_t              mem [0:ARENA_BYTES-1];
	hdr_t              rd_q;
	logic              rd_inv_q;
	logic              v0_q;
	logic              done_q;
	rsp_t              result_q;

	hdr_t              view;
	logic [ADDR_W-1:0] ra;
	logic [SUM_W-1:0]  walk_next;
	logic [SUM_W-1:0]  merged_size;
	logic [SUM_W-1:0]  merge_next;
	logic [SUM_W-1:0]  skip_next;
	logic [ADDR_W-1:0] target;
	logic [ADDR_W-1:0] nb;
	logic [SIZE_W-1:0] split_size;
	logic [REQ_W:0]    split_need;
	logic              wr_en;
	logic [ADDR_W-1:0] wa;
	hdr_t              wd;

	// Header as read; entry 0 reads as its reset value until first written
	assign view = rd_inv_q ? HDR_RESET : rd_q;
	assign ra   = cmd.rd_nx ? nx_q : cur_q;

	// Chain arithmetic
	assign walk_next   = SUM_W'(cur_q) + HDR_S + SUM_W'(view.size);
	assign merged_size = SUM_W'(hold_size_q) + HDR_S + SUM_W'(view.size);
	assign merge_next  = SUM_W'(cur_q) + HDR_S + merged_size;
	assign skip_next   = SUM_W'(nx_q) + HDR_S + SUM_W'(view.size);
	assign target      = in_q.release_offset - ADDR_W'(HEADER_BYTES);
	assign nb          = cur_q + ADDR_W'(HEADER_BYTES) + in_q.request_size[ADDR_W-1:0];
	assign split_size  = view.size - in_q.request_size[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
	assign split_need  = {1'b0, in_q.request_size} + (REQ_W+1)'(HEADER_BYTES + SPLIT_SLACK);

	// Status toward the controller
	always_comb begin
		sts.op_rel      = (in_q.operation == OP_RELEASE);
		sts.is_null     = in_q.release_is_null;
		sts.roff_low    = (in_q.release_offset < ADDR_W'(HEADER_BYTES));
		sts.fit         = view.free && ((REQ_W)'(view.size) >= in_q.request_size);
		sts.split       = ((REQ_W+1)'(view.size) >= split_need);
		sts.walk_end    = (walk_next >= ARENA_S);
		sts.at_target   = (cur_q == target);
		sts.past_target = (cur_q > target);
		sts.both_free   = hold_free_q && view.free;
		sts.merged_end  = (merge_next >= ARENA_S);
		sts.skip_end    = (skip_next >= ARENA_S);
	end

	// Header write port
	always_comb begin
		wr_en = 1'b1;
		wa    = cur_q;
		wd    = view;
		case (cmd.wr_op)
			WR_NONE: begin
				wr_en = 1'b0;
			end
			WR_SPLIT_NEW: begin
				wa = nb;
				wd = '{free: 1'b1, size: split_size};
			end
			WR_TAKE_REQ: begin
				wd = '{free: 1'b0, size: in_q.request_size[SIZE_W-1:0]};
			end
			WR_TAKE_ALL: begin
				wd = '{free: 1'b0, size: view.size};
			end
			WR_MARK_FREE: begin
				wd = '{free: 1'b1, size: view.size};
			end
			WR_MERGE: begin
				wd = '{free: 1'b1, size: merged_size[SIZE_W-1:0]};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Header memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// Entry 0 valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q     <= 1'b0;
			rd_inv_q <= 1'b0;
		end else begin
			rd_inv_q <= (ra == '0) && !v0_q;
			if (wr_en && (wa == '0)) begin
				v0_q <= 1'b1;
			end
		end
	end

	// Walk cursor, look-ahead pointer and held header
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= request;
		end
		if (cmd.cur_zero) begin
			cur_q <= '0;
		end else if (cmd.cur_walk) begin
			cur_q <= walk_next[ADDR_W-1:0];
		end else if (cmd.skip) begin
			cur_q <= nx_q;
		end
		if (cmd.hold_load) begin
			hold_free_q <= view.free;
			hold_size_q <= view.size;
			nx_q        <= walk_next[ADDR_W-1:0];
		end else if (cmd.skip) begin
			hold_free_q <= view.free;
			hold_size_q <= view.size;
			nx_q        <= skip_next[ADDR_W-1:0];
		end else if (cmd.merge) begin
			hold_size_q <= merged_size[SIZE_W-1:0];
			nx_q        <= merge_next[ADDR_W-1:0];
		end
	end

	// Result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.status         <= cmd.fin_status;
			result_q.granted_offset <= (cmd.fin_status == ST_GRANTED) ?
				(cur_q + 10'(HEADER_BYTES)) : 10'd0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/ffpa_ctrl.sv @@
module ffpa_ctrl import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_A_RD = 4'd2;
	localparam logic [3:0] S_A_EV = 4'd3;
	localparam logic [3:0] S_A_TK = 4'd4;
	localparam logic [3:0] S_R_RD = 4'd5;
	localparam logic [3:0] S_R_EV = 4'd6;
	localparam logic [3:0] S_M_RC = 4'd7;
	localparam logic [3:0] S_M_EC = 4'd8;
	localparam logic [3:0] S_M_RN = 4'd9;
	localparam logic [3:0] S_M_EN = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_in  = 1'b1;
					cmd.cur_zero = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				if (!sts.op_rel) begin
					state_d = S_A_RD;
				end else if (sts.is_null) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NULL;
					state_d        = S_IDLE;
				end else if (sts.roff_low) begin
					state_d = S_M_RC;
				end else begin
					state_d = S_R_RD;
				end
			end
			// first-fit search
			S_A_RD: begin
				state_d = S_A_EV;
			end
			S_A_EV: begin
				if (sts.fit) begin
					if (sts.split) begin
						cmd.wr_op = WR_SPLIT_NEW;
						state_d   = S_A_TK;
					end else begin
						cmd.wr_op      = WR_TAKE_ALL;
						cmd.finish     = 1'b1;
						cmd.fin_status = ST_GRANTED;
						state_d        = S_IDLE;
					end
				end else if (sts.walk_end) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NO_FIT;
					state_d        = S_IDLE;
				end else begin
					cmd.cur_walk = 1'b1;
					state_d      = S_A_RD;
				end
			end
			S_A_TK: begin
				cmd.wr_op      = WR_TAKE_REQ;
				cmd.finish     = 1'b1;
				cmd.fin_status = ST_GRANTED;
				state_d        = S_IDLE;
			end
			// release: find the block on the chain
			S_R_RD: begin
				state_d = S_R_EV;
			end
			S_R_EV: begin
				if (sts.at_target) begin
					cmd.wr_op    = WR_MARK_FREE;
					cmd.cur_zero = 1'b1;
					state_d      = S_M_RC;
				end else if (sts.past_target || sts.walk_end) begin
					cmd.cur_zero = 1'b1;
					state_d      = S_M_RC;
				end else begin
					cmd.cur_walk = 1'b1;
					state_d      = S_R_RD;
				end
			end
			// coalescing pass over the whole chain
			S_M_RC: begin
				state_d = S_M_EC;
			end
			S_M_EC: begin
				cmd.hold_load = 1'b1;
				if (sts.walk_end) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_RELEASED;
					state_d        = S_IDLE;
				end else begin
					state_d = S_M_RN;
				end
			end
			S_M_RN: begin
				cmd.rd_nx = 1'b1;
				state_d   = S_M_EN;
			end
			S_M_EN: begin
				if (sts.both_free) begin
					cmd.merge = 1'b1;
					cmd.wr_op = WR_MERGE;
					if (sts.merged_end) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = ST_RELEASED;
						state_d        = S_IDLE;
					end else begin
						state_d = S_M_RN;
					end
				end else begin
					cmd.skip = 1'b1;
					if (sts.skip_end) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = ST_RELEASED;
						state_d        = S_IDLE;
					end else begin
						state_d = S_M_RN;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/first_fit_pool_allocator_unit.sv @@
// Steps: a null release answers from dispatch; an allocation reads and evaluates each block visited,
// with an extra take step on a split; a release walks to the target, then coalesces the whole chain.
// One request at a time: busy stays high until the result strobe; each step of the
// walk is one read of the header memory. The result strobe cannot be stalled.
// Reset (arst_n low) makes the arena one free block at offset 0; no clearing pass.
module first_fit_pool_allocator_unit import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output rsp_t result
);

	cmd_t cmd;
	sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	ffpa_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

`ifndef SYNTHESIS
	// result strobe only once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted request either starts work or answers at once
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request dropped");

	// non-grant results carry a zero offset
	a_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.status == ST_GRANTED) || (result.granted_offset == 10'd0)))
		else $error("offset on non-grant result");

	// header memory is written only during a request
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_op != WR_NONE) |-> busy)
		else $error("header write while idle");
`endif

endmodule
